// ===== design/dta_pkg.sv =====
// Shared types and constants for the debounced threshold alarm.
// No dependencies; imported by every module of the block.
package dta_pkg;

  // Alarm classes, as carried on the result fields
  localparam logic [1:0] CLASS_OK   = 2'd0;
  localparam logic [1:0] CLASS_WARN = 2'd1;
  localparam logic [1:0] CLASS_CRIT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DELAY_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DELAY_MS    = 3'd5;

  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [31:0] DEFAULT_DELAY_MS = 32'd4000;  // 4.0 s

  typedef struct packed {
    logic signed [23:0] sample_value;
    logic [31:0]        sample_time_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] alarm_status;
    logic [1:0] instant_class;
    logic [1:0] pending_class;
    logic       transition_active;
    logic       status_changed;
  } out_beat_t;

  // Classified sample, front to back
  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] time_ms;
  } cls_beat_t;

  typedef struct packed {
    logic signed [23:0] low_limit;
    logic               low_limit_enable;
    logic signed [23:0] high_limit;
    logic               high_limit_enable;
    logic [31:0]        trigger_delay_ms;
    logic [31:0]        clear_delay_ms;
  } cfg_t;

endpackage

// ===== design/dta_front.sv =====
// Front stage: accepts sample beats and classifies them against the limits.
// Depends on dta_pkg.
module dta_front (
  input  logic              clk,
  input  logic              rst,
  input  dta_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  dta_pkg::in_beat_t in_data,
  output logic              push,
  output dta_pkg::cls_beat_t push_data,
  input  logic              push_ready
);
  import dta_pkg::*;

  logic      fv;
  cls_beat_t fdata;
  logic [1:0] cls;
  logic       accept;

  // WARN wins when both limits trip
  always_comb begin
    if (cfg.low_limit_enable && (in_data.sample_value < cfg.low_limit)) begin
      cls = CLASS_WARN;
    end else if (cfg.high_limit_enable && (in_data.sample_value > cfg.high_limit)) begin
      cls = CLASS_CRIT;
    end else begin
      cls = CLASS_OK;
    end
  end

  assign in_stall  = fv && !push_ready;
  assign accept    = in_valid && !in_stall;
  assign push      = fv && push_ready;
  assign push_data = fdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
    if (accept) begin
      fdata.cls     <= cls;
      fdata.time_ms <= in_data.sample_time_ms;
    end
  end

endmodule

// ===== design/dta_queue.sv =====
// Short FIFO of classified beats between front and back stages.
// Depends on dta_pkg.
module dta_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dta_pkg::cls_beat_t push_data,
  output logic               push_ready,
  input  logic               pop,
  output logic               pop_valid,
  output dta_pkg::cls_beat_t pop_data
);
  import dta_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cls_beat_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/dta_back.sv =====
// Back stage: debounce state and the registered result beat.
// Depends on dta_pkg.
module dta_back (
  input  logic               clk,
  input  logic               rst,
  input  dta_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  input  dta_pkg::cls_beat_t pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dta_pkg::out_beat_t out_data
);
  import dta_pkg::*;

  logic [1:0]  current_status, current_status_next;
  logic [1:0]  waiting_status, waiting_status_next;
  logic [31:0] transition_start_ms, transition_start_ms_next;
  logic        in_transition, in_transition_next;
  logic        changed;
  logic [31:0] elapsed;
  logic [31:0] need;
  logic        ov;
  out_beat_t   odata;

  assign pop       = pop_valid && (!ov || !out_stall);
  assign out_valid = ov;
  assign out_data  = odata;

  assign elapsed = pop_data.time_ms - transition_start_ms;
  assign need    = (pop_data.cls == CLASS_OK) ? cfg.clear_delay_ms : cfg.trigger_delay_ms;

  always_comb begin
    current_status_next      = current_status;
    waiting_status_next      = waiting_status;
    transition_start_ms_next = transition_start_ms;
    in_transition_next       = in_transition;
    changed                  = 1'b0;
    if (pop_data.cls == current_status) begin
      in_transition_next  = 1'b0;
      waiting_status_next = current_status;
    end else if (pop_data.cls == waiting_status) begin
      if (in_transition && (elapsed >= need)) begin
        current_status_next = waiting_status;
        in_transition_next  = 1'b0;
        changed             = 1'b1;
      end
    end else begin
      waiting_status_next      = pop_data.cls;
      transition_start_ms_next = pop_data.time_ms;
      in_transition_next       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_status      <= CLASS_OK;
      waiting_status      <= CLASS_OK;
      transition_start_ms <= '0;
      in_transition       <= 1'b0;
      ov                  <= 1'b0;
    end else begin
      if (pop) begin
        current_status      <= current_status_next;
        waiting_status      <= waiting_status_next;
        transition_start_ms <= transition_start_ms_next;
        in_transition       <= in_transition_next;
        ov                  <= 1'b1;
      end else if (!out_stall) begin
        ov <= 1'b0;
      end
    end
    if (pop) begin
      odata.alarm_status      <= current_status_next;
      odata.instant_class     <= pop_data.cls;
      odata.pending_class     <= waiting_status_next;
      odata.transition_active <= in_transition_next;
      odata.status_changed    <= changed;
    end
  end

endmodule

// ===== design/debounced_threshold_alarm_unit.sv =====
// Top level of the debounced threshold alarm: config registers, front, queue, back.
// Depends on dta_pkg, dta_front, dta_queue and dta_back.
// Path: a sample beat accepted into the front register passes the queue and the back output
//   register before its result beat is valid.
// Throughput: one sample per cycle while out_stall is low; the back stage's single compare-and-subtract sets it.
// Reset (rst, synchronous): status OK, no transition, queue empty, limits 0 and
//   disabled, both delays 4000 ms.
module debounced_threshold_alarm_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dta_pkg::in_beat_t               in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output dta_pkg::out_beat_t              out_data,
  // config write port
  input  logic                            cfg_we,
  input  logic [dta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dta_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dta_pkg::*;

  cfg_t      cfg;
  logic      push;
  logic      push_ready;
  cls_beat_t push_data;
  logic      pop;
  logic      pop_valid;
  cls_beat_t pop_data;

  // Config registers; writes must land only while the pipe is empty, as there is no shadowing;
  // the block itself does not enforce this. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit         <= '0;
      cfg.low_limit_enable  <= 1'b0;
      cfg.high_limit        <= '0;
      cfg.high_limit_enable <= 1'b0;
      cfg.trigger_delay_ms  <= DEFAULT_DELAY_MS;
      cfg.clear_delay_ms    <= DEFAULT_DELAY_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:         cfg.low_limit         <= cfg_data[23:0];
        REG_LOW_LIMIT_ENABLE:  cfg.low_limit_enable  <= cfg_data[0];
        REG_HIGH_LIMIT:        cfg.high_limit        <= cfg_data[23:0];
        REG_HIGH_LIMIT_ENABLE: cfg.high_limit_enable <= cfg_data[0];
        REG_TRIGGER_DELAY_MS:  cfg.trigger_delay_ms  <= cfg_data[31:0];
        REG_CLEAR_DELAY_MS:    cfg.clear_delay_ms    <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Front: take the sample, classify OK / WARN / CRIT
  dta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Queue decouples front stalls from back stalls
  dta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // Back: debounce timer and status commit, registered result beat
  dta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A commit always ends the running transition
  a_commit_ends_timer: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status_changed |-> !out_data.transition_active)
    else $error("status committed with transition still active");

  // With no timer running, the pending class tracks the status
  a_idle_pending_eq_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.transition_active |->
      out_data.pending_class == out_data.alarm_status)
    else $error("pending class differs from status with no transition");

  // A committed status is the class of the sample that committed it
  a_commit_matches_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status_changed |->
      out_data.instant_class == out_data.alarm_status)
    else $error("committed status differs from sample class");

  // Nothing reaches the output without first entering the queue
  a_pop_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop_valid))
    else $error("result beat without queued sample");

endmodule
